[hdl/blocking_bounded_queue_unit_defines.svh]
// Assertion macros used by the bounded queue top level.
`ifndef BLOCKING_BOUNDED_QUEUE_UNIT_DEFINES_SVH
`define BLOCKING_BOUNDED_QUEUE_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define BBQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define BBQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bbq_pkg.sv]
// Types, codes and field widths of the bounded queue.
package bbq_pkg;

  localparam int TAG_W   = 8;
  localparam int WORD_W  = 64;
  localparam int LIMIT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [1:0] {
    REQ_PUT  = 2'd0,
    REQ_GET  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_END  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_PUT    = 2'd0,
    KIND_GET    = 2'd1,
    KIND_PEEK   = 2'd2,
    KIND_REJECT = 2'd3
  } done_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_AFTER_END = 2'd1,
    ERR_POOL_FULL = 2'd2,
    ERR_RESERVED  = 2'd3
  } error_code_e;

  // Push/pop strobes into one ring.
  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctl_t;

  typedef struct packed {
    logic [TAG_W-1:0]  done_tag;
    logic [1:0]        done_kind;
    logic              success;
    logic [WORD_W-1:0] out_data;
    logic [1:0]        error_code;
  } result_t;

  function automatic result_t mk_res(input logic [TAG_W-1:0] tag, input done_kind_e kind,
                                     input logic ok, input logic [WORD_W-1:0] data,
                                     input error_code_e err);
    result_t r;
    r.done_tag   = tag;
    r.done_kind  = kind;
    r.success    = ok;
    r.out_data   = data;
    r.error_code = err;
    return r;
  endfunction

endpackage

[hdl/bbq_channels.sv]
// Handshake channels of the bounded queue: requests, results, configuration.
interface bbq_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [bbq_pkg::TAG_W-1:0]   op_tag;
  logic [bbq_pkg::WORD_W-1:0]  item_data;

  modport source (output valid, req_type, op_tag, item_data, input ready);
  modport sink   (input valid, req_type, op_tag, item_data, output ready);
endinterface

interface bbq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bbq_pkg::TAG_W-1:0]   done_tag;
  logic [1:0]                  done_kind;
  logic                        success;
  logic [bbq_pkg::WORD_W-1:0]  out_data;
  logic [1:0]                  error_code;
  logic                        last;

  modport source (output valid, done_tag, done_kind, success, out_data, error_code, last,
                  input ready);
  modport sink   (input valid, done_tag, done_kind, success, out_data, error_code, last,
                  output ready);
endinterface

interface bbq_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bbq_pkg::LIMIT_W-1:0]  queue_limit;

  modport source (output valid, queue_limit, input ready);
  modport sink   (input valid, queue_limit, output ready);
endinterface

[hdl/bbq_ring.sv]
// Circular buffer in a synchronous memory with a prefetched head word.
module bbq_ring #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bbq_pkg::ring_ctl_t        ctl_i,
  input  logic [WIDTH-1:0]          push_data_i,
  output logic [$clog2(DEPTH+1)-1:0] count_o,
  output logic [WIDTH-1:0]          head_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [WIDTH-1:0] rd_q, byp_data_q;
  logic             byp_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    head_d  = ctl_i.pop  ? ptr_inc(head_q) : head_q;
    tail_d  = ctl_i.push ? ptr_inc(tail_q) : tail_q;
    count_d = count_q + CntW'(ctl_i.push) - CntW'(ctl_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Read the next head every cycle; forward a write that lands on it.
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[tail_q] <= push_data_i;
    end
    rd_q       <= mem_q[head_d];
    byp_q      <= ctl_i.push && (tail_q == head_d);
    byp_data_q <= push_data_i;
  end

  assign head_o  = byp_q ? byp_data_q : rd_q;
  assign count_o = count_q;

endmodule

[hdl/blocking_bounded_queue_unit.sv]
// Top level of the bounded blocking queue with end-of-stream.
//
// Channels: req_i carries put, get, peek and end-of-stream requests; rsp_o
// returns result items, with last set on the final result of each request;
// cfg_i writes queue_limit (reset 16, 0 acts as 1, above QUEUE_DEPTH acts as
// QUEUE_DEPTH). Write it only while the block is idle.
// Timing: a result given as a request is taken is registered, then shows
// on rsp_o. While rsp_o does not stall: a request with one or no result,
// other than an end of stream with parked gets, frees the block for the
// next request at once, so one request per cycle is sustained; a request
// with two results (a put that serves a parked get, a get that frees a
// parked put) emits the second from ST_SECOND; an end of stream with
// parked gets fails them from ST_DRAIN, one per cycle. The rate is set by
// the single result register and the one-pop-per-cycle waiter ring heads.
// Words and parked tags sit in three ring memories with registered reads;
// each ring keeps its head word prefetched, forwarding a same-cycle write.
// Reset clears pointers, counts, the end flag and the output register; the
// memory contents are not cleared. While rsp_o stalls, the result register
// holds and no request is taken.
`include "blocking_bounded_queue_unit_defines.svh"

module blocking_bounded_queue_unit #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int MAX_PRODUCERS = 8,
  parameter int MAX_CONSUMERS = 8,
  parameter int DATA_WIDTH    = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bbq_req_if.sink    req_i,
  bbq_rsp_if.source  rsp_o,
  bbq_cfg_if.sink    cfg_i
);

  localparam int StoreDepth = QUEUE_DEPTH + MAX_PRODUCERS;
  localparam int ItemCntW   = $clog2(StoreDepth + 1);
  localparam int PutCntW    = $clog2(MAX_PRODUCERS + 1);
  localparam int GetCntW    = $clog2(MAX_CONSUMERS + 1);
  localparam int CmpW       = (ItemCntW > bbq_pkg::LIMIT_W) ? ItemCntW : bbq_pkg::LIMIT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SECOND,
    ST_DRAIN
  } state_e;

  state_e                        state_q;
  logic                          out_vld_q, last_q, ended_q;
  bbq_pkg::result_t              res_q, pend_q;
  logic [bbq_pkg::LIMIT_W-1:0]   limit_q;

  // Ring interfaces
  bbq_pkg::ring_ctl_t            item_ctl, pput_ctl, pget_ctl;
  logic [ItemCntW-1:0]           item_cnt;
  logic [PutCntW-1:0]            put_cnt;
  logic [GetCntW-1:0]            get_cnt;
  logic [DATA_WIDTH-1:0]         item_head, put_word;
  logic [bbq_pkg::TAG_W-1:0]     put_head, get_head;

  // Request decode
  logic                          slot_free, req_fire, cfg_fire;
  logic [CmpW-1:0]               lim_raw, lim_eff;
  logic                          full, item_empty, get_waiting, put_pool_full, get_pool_full;
  logic [bbq_pkg::WORD_W-1:0]    put_word_ext, head_word_ext;
  logic                          r1_vld, r2_vld, set_ended, go_drain;
  bbq_pkg::result_t              r1, r2, emit_res;
  logic                          emit_vld, emit_last, drain_pop, drain_last;

  assign slot_free   = !out_vld_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && slot_free;
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  // Clamp the limit into 1..QUEUE_DEPTH.
  assign lim_raw = CmpW'(limit_q);
  always_comb begin
    if (lim_raw == '0) begin
      lim_eff = CmpW'(1);
    end else if (lim_raw > CmpW'(QUEUE_DEPTH)) begin
      lim_eff = CmpW'(QUEUE_DEPTH);
    end else begin
      lim_eff = lim_raw;
    end
  end

  assign full          = CmpW'(item_cnt) >= lim_eff;
  assign item_empty    = (item_cnt == '0);
  assign get_waiting   = (get_cnt != '0);
  assign put_pool_full = (put_cnt == PutCntW'(MAX_PRODUCERS));
  assign get_pool_full = (get_cnt == GetCntW'(MAX_CONSUMERS));
  assign put_word      = DATA_WIDTH'(req_i.item_data);
  assign put_word_ext  = bbq_pkg::WORD_W'(put_word);
  assign head_word_ext = bbq_pkg::WORD_W'(item_head);

  assign drain_pop  = (state_q == ST_DRAIN) && slot_free;
  assign drain_last = (get_cnt == GetCntW'(1));

  // Decide the ring updates and up to two results of an accepted request.
  always_comb begin
    item_ctl  = '0;
    pput_ctl  = '0;
    pget_ctl  = '0;
    r1_vld    = 1'b0;
    r2_vld    = 1'b0;
    r1        = '0;
    r2        = '0;
    set_ended = 1'b0;
    go_drain  = 1'b0;
    if (req_fire) begin
      unique case (bbq_pkg::req_type_e'(req_i.req_type))
        bbq_pkg::REQ_PUT: begin
          r1_vld = 1'b1;
          if (ended_q) begin
            r1 = bbq_pkg::mk_res(req_i.op_tag, bbq_pkg::KIND_REJECT, 1'b0, '0,
                                 bbq_pkg::ERR_AFTER_END);
          end else if (full && put_pool_full) begin
            r1 = bbq_pkg::mk_res(req_i.op_tag, bbq_pkg::KIND_REJECT, 1'b0, '0,
                                 bbq_pkg::ERR_POOL_FULL);
          end else begin
            item_ctl.push = 1'b1;
            pput_ctl.push = full;
            r1_vld        = !full;
            r1 = bbq_pkg::mk_res(req_i.op_tag, bbq_pkg::KIND_PUT, 1'b0, '0,
                                 bbq_pkg::ERR_NONE);
            if (get_waiting) begin
              // Queue is empty here, so the served word is this put's own.
              pget_ctl.pop = 1'b1;
              item_ctl.pop = 1'b1;
              if (full) begin
                r1_vld = 1'b1;
                r1 = bbq_pkg::mk_res(get_head, bbq_pkg::KIND_GET, 1'b1, put_word_ext,
                                     bbq_pkg::ERR_NONE);
              end else begin
                r2_vld = 1'b1;
                r2 = bbq_pkg::mk_res(get_head, bbq_pkg::KIND_GET, 1'b1, put_word_ext,
                                     bbq_pkg::ERR_NONE);
              end
            end
          end
        end
        bbq_pkg::REQ_GET: begin
          if (item_empty && ended_q) begin
            r1_vld = 1'b1;
            r1 = bbq_pkg::mk_res(req_i.op_tag, bbq_pkg::KIND_GET, 1'b0, '0,
                                 bbq_pkg::ERR_NONE);
          end else if (item_empty || get_waiting) begin
            if (get_pool_full) begin
              r1_vld = 1'b1;
              r1 = bbq_pkg::mk_res(req_i.op_tag, bbq_pkg::KIND_REJECT, 1'b0, '0,
                                   bbq_pkg::ERR_POOL_FULL);
            end else begin
              pget_ctl.push = 1'b1;
            end
          end else begin
            item_ctl.pop = 1'b1;
            r1_vld = 1'b1;
            r1 = bbq_pkg::mk_res(req_i.op_tag, bbq_pkg::KIND_GET, 1'b1, head_word_ext,
                                 bbq_pkg::ERR_NONE);
            if (put_cnt != '0) begin
              pput_ctl.pop = 1'b1;
              r2_vld = 1'b1;
              r2 = bbq_pkg::mk_res(put_head, bbq_pkg::KIND_PUT, 1'b0, '0,
                                   bbq_pkg::ERR_NONE);
            end
          end
        end
        bbq_pkg::REQ_PEEK: begin
          r1_vld = 1'b1;
          if (item_empty || get_waiting) begin
            r1 = bbq_pkg::mk_res(req_i.op_tag, bbq_pkg::KIND_PEEK, 1'b0, '0,
                                 bbq_pkg::ERR_NONE);
          end else begin
            r1 = bbq_pkg::mk_res(req_i.op_tag, bbq_pkg::KIND_PEEK, 1'b1, head_word_ext,
                                 bbq_pkg::ERR_NONE);
          end
        end
        bbq_pkg::REQ_END: begin
          if (ended_q) begin
            r1_vld = 1'b1;
            r1 = bbq_pkg::mk_res(req_i.op_tag, bbq_pkg::KIND_REJECT, 1'b0, '0,
                                 bbq_pkg::ERR_AFTER_END);
          end else begin
            set_ended = 1'b1;
            go_drain  = get_waiting;
          end
        end
        default: begin
          r1_vld = 1'b0;
        end
      endcase
    end
    // Fail parked gets one per cycle after end of stream, while rsp_o does not stall.
    if (drain_pop) begin
      pget_ctl.pop = 1'b1;
    end
  end

  // Pick what enters the result register this cycle.
  always_comb begin
    emit_vld  = 1'b0;
    emit_res  = r1;
    emit_last = !r2_vld;
    unique case (state_q)
      ST_IDLE: begin
        emit_vld = r1_vld;
      end
      ST_SECOND: begin
        emit_vld  = slot_free;
        emit_res  = pend_q;
        emit_last = 1'b1;
      end
      ST_DRAIN: begin
        emit_vld  = slot_free;
        emit_res  = bbq_pkg::mk_res(get_head, bbq_pkg::KIND_GET, 1'b0, '0,
                                    bbq_pkg::ERR_NONE);
        emit_last = drain_last;
      end
      default: begin
        emit_vld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      last_q    <= 1'b0;
      res_q     <= '0;
      pend_q    <= '0;
      ended_q   <= 1'b0;
      limit_q   <= bbq_pkg::LIMIT_RESET;
    end else begin
      if (cfg_fire) begin
        limit_q <= cfg_i.queue_limit;
      end
      if (set_ended) begin
        ended_q <= 1'b1;
      end
      // Load a new result, or drop the old one once taken.
      if (emit_vld) begin
        out_vld_q <= 1'b1;
        res_q     <= emit_res;
        last_q    <= emit_last;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            if (r2_vld) begin
              pend_q  <= r2;
              state_q <= ST_SECOND;
            end else if (go_drain) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_SECOND: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        ST_DRAIN: begin
          if (slot_free && drain_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.done_tag   = res_q.done_tag;
  assign rsp_o.done_kind  = res_q.done_kind;
  assign rsp_o.success    = res_q.success;
  assign rsp_o.out_data   = res_q.out_data;
  assign rsp_o.error_code = res_q.error_code;
  assign rsp_o.last       = last_q;

  // Stored words, oldest first.
  bbq_ring #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (StoreDepth)
  ) u_item_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (item_ctl),
    .push_data_i (put_word),
    .count_o     (item_cnt),
    .head_o      (item_head)
  );

  // Tags of parked puts.
  bbq_ring #(
    .WIDTH (bbq_pkg::TAG_W),
    .DEPTH (MAX_PRODUCERS)
  ) u_put_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (pput_ctl),
    .push_data_i (req_i.op_tag),
    .count_o     (put_cnt),
    .head_o      (put_head)
  );

  // Tags of parked gets.
  bbq_ring #(
    .WIDTH (bbq_pkg::TAG_W),
    .DEPTH (MAX_CONSUMERS)
  ) u_get_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (pget_ctl),
    .push_data_i (req_i.op_tag),
    .count_o     (get_cnt),
    .head_o      (get_head)
  );

  `BBQ_ASSERT_IMPL(a_get_wait_empty, get_cnt != '0, item_cnt == '0, "parked get with stored words")
  `BBQ_ASSERT_IMPL(a_wait_exclusive, put_cnt != '0, get_cnt == '0, "puts and gets parked at once")
  `BBQ_ASSERT_IMPL(a_drain_has_get, state_q == ST_DRAIN, get_cnt != '0, "drain with no parked get")
  `BBQ_ASSERT_NEXT(a_result_shown, req_fire && r1_vld, rsp_o.valid, "accepted result not shown")

endmodule

[tb/blocking_bounded_queue_unit_tb.sv]
// Self-checking testbench for the bounded blocking queue with end of stream.
`timescale 1ns / 1ps

module blocking_bounded_queue_unit_tb;

  localparam int QUEUE_DEPTH    = 16;
  localparam int MAX_PRODUCERS  = 8;
  localparam int MAX_CONSUMERS  = 8;
  localparam int DATA_WIDTH     = 64;
  localparam int RESET_CYCLES   = 10;
  // Idle time after the last expected result, which also covers requests
  // that park and return nothing.
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_REQUESTS = 10;

  // One result as the predictor expects it.
  typedef struct {
    logic [bbq_pkg::TAG_W-1:0]  tag;
    bbq_pkg::done_kind_e        kind;
    logic                       ok;
    logic [bbq_pkg::WORD_W-1:0] word;
    bbq_pkg::error_code_e       err;
    logic                       last;
  } completion_t;

  logic clk_i;
  logic rst_ni;

  bbq_req_if req_if ();
  bbq_rsp_if rsp_if ();
  bbq_cfg_if cfg_if ();

  blocking_bounded_queue_unit #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .MAX_PRODUCERS(MAX_PRODUCERS),
    .MAX_CONSUMERS(MAX_CONSUMERS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  // Queue state as the predictor sees it.
  logic [bbq_pkg::WORD_W-1:0]  stored_words[$];
  logic [bbq_pkg::TAG_W-1:0]   parked_puts[$];
  logic [bbq_pkg::TAG_W-1:0]   parked_gets[$];
  logic                        stream_closed;
  logic [bbq_pkg::LIMIT_W-1:0] limit_setting;

  completion_t awaited_results[$];
  int          mismatch_count;
  int          idle_cycles;
  int          burst_left;
  int          flow_left;
  int          stall_left;
  logic [bbq_pkg::TAG_W-1:0] next_tag;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic completion_t completion(logic [bbq_pkg::TAG_W-1:0] tag,
                                             bbq_pkg::done_kind_e kind, logic ok,
                                             logic [bbq_pkg::WORD_W-1:0] word,
                                             bbq_pkg::error_code_e err);
    completion_t c;
    c.tag  = tag;
    c.kind = kind;
    c.ok   = ok;
    c.word = word;
    c.err  = err;
    c.last = 1'b0;
    return c;
  endfunction

  // Advance the predicted queue by one taken request and queue up the
  // results it must produce, in order, with last on the final one.
  function automatic void predict_request(bbq_pkg::req_type_e kind,
                                          logic [bbq_pkg::TAG_W-1:0] tag,
                                          logic [bbq_pkg::WORD_W-1:0] word);
    completion_t batch[$];
    int unsigned lim;
    bit          full;
    lim = 32'(limit_setting);
    // Zero acts as one, anything above the depth acts as the depth.
    if (lim < 1) lim = 1;
    if (lim > QUEUE_DEPTH) lim = QUEUE_DEPTH;
    case (kind)
      bbq_pkg::REQ_PUT: begin
        full = stored_words.size() >= lim;
        if (stream_closed) begin
          batch.push_back(completion(tag, bbq_pkg::KIND_REJECT, 1'b0, '0,
                                     bbq_pkg::ERR_AFTER_END));
        end else if (full && parked_puts.size() >= MAX_PRODUCERS) begin
          batch.push_back(completion(tag, bbq_pkg::KIND_REJECT, 1'b0, '0,
                                     bbq_pkg::ERR_POOL_FULL));
        end else begin
          // The word is stored even when the put itself has to wait.
          stored_words.push_back(word);
          if (full) parked_puts.push_back(tag);
          else batch.push_back(completion(tag, bbq_pkg::KIND_PUT, 1'b0, '0,
                                          bbq_pkg::ERR_NONE));
          if (parked_gets.size() > 0) begin
            batch.push_back(completion(parked_gets.pop_front(), bbq_pkg::KIND_GET, 1'b1,
                                       stored_words.pop_front(), bbq_pkg::ERR_NONE));
          end
        end
      end
      bbq_pkg::REQ_GET: begin
        if (stored_words.size() == 0 && stream_closed) begin
          batch.push_back(completion(tag, bbq_pkg::KIND_GET, 1'b0, '0, bbq_pkg::ERR_NONE));
        end else if (stored_words.size() == 0 || parked_gets.size() > 0) begin
          if (parked_gets.size() >= MAX_CONSUMERS) begin
            batch.push_back(completion(tag, bbq_pkg::KIND_REJECT, 1'b0, '0,
                                       bbq_pkg::ERR_POOL_FULL));
          end else begin
            parked_gets.push_back(tag);
          end
        end else begin
          batch.push_back(completion(tag, bbq_pkg::KIND_GET, 1'b1, stored_words.pop_front(),
                                     bbq_pkg::ERR_NONE));
          // A freed slot releases the oldest waiting put.
          if (parked_puts.size() > 0) begin
            batch.push_back(completion(parked_puts.pop_front(), bbq_pkg::KIND_PUT, 1'b0, '0,
                                       bbq_pkg::ERR_NONE));
          end
        end
      end
      bbq_pkg::REQ_PEEK: begin
        if (stored_words.size() == 0 || parked_gets.size() > 0) begin
          batch.push_back(completion(tag, bbq_pkg::KIND_PEEK, 1'b0, '0, bbq_pkg::ERR_NONE));
        end else begin
          batch.push_back(completion(tag, bbq_pkg::KIND_PEEK, 1'b1, stored_words[0],
                                     bbq_pkg::ERR_NONE));
        end
      end
      default: begin
        if (stream_closed) begin
          batch.push_back(completion(tag, bbq_pkg::KIND_REJECT, 1'b0, '0,
                                     bbq_pkg::ERR_AFTER_END));
        end else begin
          // Close the stream and fail every waiting get, oldest first.
          stream_closed = 1'b1;
          while (parked_gets.size() > 0) begin
            batch.push_back(completion(parked_gets.pop_front(), bbq_pkg::KIND_GET, 1'b0, '0,
                                       bbq_pkg::ERR_NONE));
          end
        end
      end
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) awaited_results.push_back(batch[i]);
  endfunction

  function automatic void check_field(string name, logic [bbq_pkg::WORD_W-1:0] want,
                                      logic [bbq_pkg::WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare every taken result with the oldest expectation.
  always @(posedge clk_i) begin
    completion_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result with no request pending: done_tag 'h%0h", rsp_if.done_tag);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("done_tag", bbq_pkg::WORD_W'(want.tag),
                    bbq_pkg::WORD_W'(rsp_if.done_tag));
        check_field("done_kind", bbq_pkg::WORD_W'(want.kind),
                    bbq_pkg::WORD_W'(rsp_if.done_kind));
        check_field("success", bbq_pkg::WORD_W'(want.ok),
                    bbq_pkg::WORD_W'(rsp_if.success));
        check_field("out_data", want.word, rsp_if.out_data);
        check_field("error_code", bbq_pkg::WORD_W'(want.err),
                    bbq_pkg::WORD_W'(rsp_if.error_code));
        check_field("last", bbq_pkg::WORD_W'(want.last),
                    bbq_pkg::WORD_W'(rsp_if.last));
      end
    end
  end

  // Stall the result channel in bursts; some stretches run with no stall.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else if (flow_left > 0) begin
      rsp_if.ready <= 1'b1;
      flow_left--;
    end else begin
      rsp_if.ready <= 1'b1;
      flow_left  = $urandom_range(1, 24);
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
    end
  end

  // End the run if no channel moves anything for too long.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Drive one request and hold it until taken. Call at a falling edge;
  // returns at the falling edge after the request was taken.
  task automatic send_request(bbq_pkg::req_type_e kind, logic [bbq_pkg::TAG_W-1:0] tag,
                              logic [bbq_pkg::WORD_W-1:0] word);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.op_tag    <= tag;
    req_if.item_data <= word;
    do @(posedge clk_i); while (!req_if.ready);
    predict_request(kind, tag, word);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Hold off requests until every expected result has come back, then let
  // the block settle so that the queue limit may be rewritten.
  task automatic wait_for_quiet();
    req_if.valid <= 1'b0;
    while (awaited_results.size() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_queue_limit(logic [bbq_pkg::LIMIT_W-1:0] value);
    cfg_if.valid       <= 1'b1;
    cfg_if.queue_limit <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    limit_setting = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [bbq_pkg::TAG_W-1:0] fresh_tag();
    next_tag++;
    return next_tag;
  endfunction

  // Empty queue, parked get served by a put, extreme tags and words, peek.
  task automatic test_basic_traffic();
    send_request(bbq_pkg::REQ_PEEK, 8'd1, '0);
    send_request(bbq_pkg::REQ_GET, 8'd2, '0);
    send_request(bbq_pkg::REQ_PEEK, 8'd3, '1);
    send_request(bbq_pkg::REQ_PUT, 8'd0, '1);
    send_request(bbq_pkg::REQ_PUT, 8'd255, '0);
    send_request(bbq_pkg::REQ_PUT, 8'd4, 64'h5A5A_A5A5_0F0F_F0F0);
    send_request(bbq_pkg::REQ_PEEK, 8'd5, '0);
    send_request(bbq_pkg::REQ_GET, 8'd6, '0);
    send_request(bbq_pkg::REQ_GET, 8'd7, '0);
  endtask

  // Limit of one: fill the put waiter pool, overflow it, then release it.
  task automatic test_producer_pool();
    wait_for_quiet();
    write_queue_limit(5'd1);
    repeat (MAX_PRODUCERS + 2) send_request(bbq_pkg::REQ_PUT, fresh_tag(), {$urandom, $urandom});
    send_request(bbq_pkg::REQ_PEEK, fresh_tag(), '0);
    repeat (MAX_PRODUCERS + 1) send_request(bbq_pkg::REQ_GET, fresh_tag(), '0);
  endtask

  // Random puts, gets and peeks under several limits, extremes included.
  // Each limit change drains every pending result first.
  task automatic test_random_traffic();
    logic [bbq_pkg::LIMIT_W-1:0] limits[6];
    int                          pick;
    limits = '{5'd0, 5'd31, 5'd3, 5'd17, bbq_pkg::LIMIT_W'($urandom_range(1, 16)),
               bbq_pkg::LIMIT_RESET};
    foreach (limits[p]) begin
      wait_for_quiet();
      write_queue_limit(limits[p]);
      repeat (PHASE_REQUESTS) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) send_request(bbq_pkg::REQ_PUT, fresh_tag(), {$urandom, $urandom});
        else if (pick < 85) send_request(bbq_pkg::REQ_GET, fresh_tag(), {$urandom, $urandom});
        else send_request(bbq_pkg::REQ_PEEK, fresh_tag(), {$urandom, $urandom});
      end
    end
  endtask

  // Drain the queue, fill the get waiter pool and overflow it, then close
  // the stream and check every request type after the close.
  task automatic test_end_of_stream();
    while (stored_words.size() > 0) send_request(bbq_pkg::REQ_GET, fresh_tag(), '0);
    while (parked_gets.size() < MAX_CONSUMERS) send_request(bbq_pkg::REQ_GET, fresh_tag(), '0);
    send_request(bbq_pkg::REQ_GET, fresh_tag(), '0);
    send_request(bbq_pkg::REQ_PEEK, fresh_tag(), '0);
    send_request(bbq_pkg::REQ_END, fresh_tag(), '0);
    send_request(bbq_pkg::REQ_PUT, fresh_tag(), {$urandom, $urandom});
    send_request(bbq_pkg::REQ_END, fresh_tag(), '0);
    send_request(bbq_pkg::REQ_GET, fresh_tag(), '0);
    send_request(bbq_pkg::REQ_PEEK, fresh_tag(), '0);
  endtask

  initial begin
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= bbq_pkg::REQ_PUT;
    req_if.op_tag      <= '0;
    req_if.item_data   <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.queue_limit <= bbq_pkg::LIMIT_RESET;
    stream_closed   = 1'b0;
    limit_setting   = bbq_pkg::LIMIT_RESET;
    mismatch_count  = 0;
    idle_cycles     = 0;
    burst_left      = 0;
    flow_left       = 0;
    stall_left      = 0;
    next_tag        = 8'd7;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_basic_traffic();
    test_producer_pool();
    test_random_traffic();
    test_end_of_stream();

    wait_for_quiet();
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/bbq_pkg.sv
hdl/bbq_channels.sv
hdl/bbq_ring.sv
hdl/blocking_bounded_queue_unit.sv
tb/blocking_bounded_queue_unit_tb.sv
